>>> hw/rtl/rsym_pkg.sv
// ----------------------------------------------------------------------------
// Radix symbol converter package
// Shared types and constants for the signed integer to radix text converter.
// ----------------------------------------------------------------------------
package rsym_pkg;

  localparam int SYM_COUNT = 16;

  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_DEL   = 8'd127;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;

  localparam logic [1:0] CFG_BASE_LENGTH  = 2'd0;
  localparam logic [1:0] CFG_SYMBOLS_LOW  = 2'd1;
  localparam logic [1:0] CFG_SYMBOLS_HIGH = 2'd2;

  typedef struct packed {
    logic [4:0]                 base_length;
    logic [SYM_COUNT-1:0][7:0]  symbols;
  } rsym_alpha_t;

endpackage

>>> hw/rtl/rsym_front.sv
// ----------------------------------------------------------------------------
// Radix symbol converter front end
// Accepts input values, checks the alphabet and queues sign and magnitude.
// ----------------------------------------------------------------------------
module rsym_front #(
  parameter int MAX_SYMBOLS = 16,
  parameter int VALUE_BITS  = 32
) (
  input  rsym_pkg::rsym_alpha_t          alpha,
  input  logic                           cfg_busy,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [VALUE_BITS-1:0]   in_value,
  input  logic                           q_full,
  output logic                           q_push,
  output logic [VALUE_BITS:0]            q_push_data
);
  import rsym_pkg::*;

  logic                  alpha_ok;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;

  always_comb begin
    alpha_ok = (alpha.base_length >= 5'd2) && (alpha.base_length <= 5'(MAX_SYMBOLS));
    for (int i = 0; i < SYM_COUNT; i++) begin
      if (5'(i) < alpha.base_length) begin
        if ((alpha.symbols[i] <= CHAR_SPACE) || (alpha.symbols[i] >= CHAR_DEL) ||
            (alpha.symbols[i] == CHAR_MINUS) || (alpha.symbols[i] == CHAR_PLUS)) begin
          alpha_ok = 1'b0;
        end
        for (int j = i + 1; j < SYM_COUNT; j++) begin
          if ((5'(j) < alpha.base_length) && (alpha.symbols[i] == alpha.symbols[j])) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  assign neg = in_value[VALUE_BITS-1];
  assign mag = neg ? (~$unsigned(in_value) + 1'b1) : $unsigned(in_value);

  assign in_ready    = !q_full && !cfg_busy;
  assign q_push      = in_valid && in_ready && alpha_ok;
  assign q_push_data = {neg, mag};

endmodule

>>> hw/rtl/rsym_queue.sv
// ----------------------------------------------------------------------------
// Radix symbol converter queue
// Short register queue between the front end and the digit engine.
// ----------------------------------------------------------------------------
module rsym_queue #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] pop_data
);
  import rsym_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue written while full");
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue read while empty");
`endif

endmodule

>>> hw/rtl/rsym_back.sv
// ----------------------------------------------------------------------------
// Radix symbol converter digit engine
// Shifts the magnitude into a row of radix digit cells, then sends the sign
// and the digit symbols, most significant first.
// ----------------------------------------------------------------------------
module rsym_back #(
  parameter int VALUE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rsym_pkg::rsym_alpha_t  alpha,
  input  logic                   q_valid,
  input  logic [VALUE_BITS:0]    q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_char_byte,
  output logic                   out_last
);
  import rsym_pkg::*;

  localparam int LANES  = VALUE_BITS;
  localparam int CNT_W  = $clog2(LANES + 1);
  localparam int DIG_W  = $clog2(LANES);
  localparam int STEP_W = $clog2(VALUE_BITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SIGN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  logic [3:0]            digit_r [LANES];
  logic [3:0]            digit_nxt [LANES];
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [4:0]            radix;
  logic [4:0]            dbl [LANES];
  logic [3:0]            digit_step [LANES];
  logic [LANES-1:0]      gen, prop;
  logic [LANES:0]        sum, carry;
  logic [CNT_W-1:0]      count_step;
  logic [CNT_W-1:0]      idx_m1;
  logic [3:0]            digit_sel;
  logic                  slot_free;

  assign radix = alpha.base_length;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      dbl[i]  = {digit_r[i], 1'b0};
      gen[i]  = (dbl[i] >= radix);
      prop[i] = (dbl[i] == (radix - 5'd1));
    end
    sum   = {1'b0, gen} + {1'b0, gen | prop} + {{LANES{1'b0}}, mag_r[VALUE_BITS-1]};
    carry = sum ^ {1'b0, gen} ^ {1'b0, gen | prop};
    for (int i = 0; i < LANES; i++) begin
      digit_step[i] = 4'((dbl[i] + {4'd0, carry[i]}) - (carry[i+1] ? radix : 5'd0));
    end
    count_step = count_r + CNT_W'(carry[count_r]);
  end

  assign idx_m1    = idx_r - 1'b1;
  assign digit_sel = digit_r[idx_m1[DIG_W-1:0]];
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    digit_nxt     = digit_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          neg_nxt   = q_data[VALUE_BITS];
          mag_nxt   = q_data[VALUE_BITS-1:0];
          for (int i = 0; i < LANES; i++) begin
            digit_nxt[i] = 4'd0;
          end
          count_nxt = CNT_W'(1);
          step_nxt  = STEP_W'(VALUE_BITS - 1);
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        digit_nxt = digit_step;
        mag_nxt   = {mag_r[VALUE_BITS-2:0], 1'b0};
        count_nxt = count_step;
        step_nxt  = step_r - 1'b1;
        if (step_r == '0) begin
          idx_nxt   = count_step;
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = alpha.symbols[digit_sel];
          out_last_nxt  = (idx_r == CNT_W'(1));
          idx_nxt       = idx_m1;
          if (idx_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    digit_r    <= digit_nxt;
    count_r    <= count_nxt;
    idx_r      <= idx_nxt;
    step_r     <= step_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_byte = out_char_r;
  assign out_last      = out_last_r;

`ifndef NO_ASSERTIONS
  a_pop_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_CONV)) else $error("queue read without conversion");
  a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (idx_r != '0)) else $error("emission with no digit left");
`endif

endmodule

>>> hw/rtl/signed_int_to_radix_symbols_top.sv
// ----------------------------------------------------------------------------
// Signed integer to radix symbols
// Converts a signed integer to text in a configurable radix and alphabet.
// ----------------------------------------------------------------------------
// Each accepted value yields its characters one transfer at a time, a minus
// sign first for negative values, then the digit symbols most significant
// first, with out_last on the final one. Values taken while the alphabet is
// invalid are accepted and produce nothing. A value is loaded, then converted
// while the magnitude is shifted one bit per cycle into a row of radix digit
// cells, and then its characters are sent one at a time as the output takes
// them; the digit engine handles one value at a time, while a two-entry queue
// lets the input side take the next values meanwhile. Configuration writes
// hold off input transfers in the same cycle and should be made only while
// the block is idle.
module signed_int_to_radix_symbols_top #(
  parameter int MAX_SYMBOLS = 16,
  parameter int VALUE_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [63:0]                  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_char_byte,
  output logic                         out_last
);
  import rsym_pkg::*;

  logic [4:0]           base_length_r, base_length_nxt;
  logic [63:0]          symbols_low_r, symbols_low_nxt;
  logic [63:0]          symbols_high_r, symbols_high_nxt;
  rsym_alpha_t          alpha;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_push;
  logic                 q_pop;
  logic [VALUE_BITS:0]  q_push_data;
  logic [VALUE_BITS:0]  q_pop_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    base_length_nxt  = base_length_r;
    symbols_low_nxt  = symbols_low_r;
    symbols_high_nxt = symbols_high_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_BASE_LENGTH:  base_length_nxt  = cfg_data[4:0];
        CFG_SYMBOLS_LOW:  symbols_low_nxt  = cfg_data;
        CFG_SYMBOLS_HIGH: symbols_high_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_length_r  <= '0;
      symbols_low_r  <= '0;
      symbols_high_r <= '0;
    end else begin
      base_length_r  <= base_length_nxt;
      symbols_low_r  <= symbols_low_nxt;
      symbols_high_r <= symbols_high_nxt;
    end
  end

  assign alpha.base_length = base_length_r;
  assign alpha.symbols     = {symbols_high_r, symbols_low_r};

  rsym_front #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_front (
    .alpha       (alpha),
    .cfg_busy    (cfg_valid),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_value    (in_value),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  rsym_queue #(
    .WIDTH (VALUE_BITS + 1),
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_pop_data)
  );

  rsym_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .alpha         (alpha),
    .q_valid       (!q_empty),
    .q_data        (q_pop_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_byte (out_char_byte),
    .out_last      (out_last)
  );

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Radix text converter testbench
// Loads a series of alphabets, both legal and rejected, and streams signed
// values through the converter, checking every character transfer against
// a predicted text under random stalls on both the input and result sides.
// ----------------------------------------------------------------------------
module tb_top;
  import rsym_pkg::*;

  localparam int MAX_SYMBOLS   = 16;
  localparam int VALUE_BITS    = 32;
  localparam int SETTLE_CYCLES = 3 * (VALUE_BITS + 34);
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 26;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_rec_t;

  typedef enum logic {ROW_CFG, ROW_VALUE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  index;
    logic [63:0] data;
    logic [31:0] value;
    bit          typed;
    string       text;
  } stim_row_t;

  typedef enum int {
    FLT_SHORT, FLT_LONG, FLT_CTRL, FLT_TOP, FLT_PLUS, FLT_MINUS, FLT_DUP
  } alpha_fault_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [1:0]                   cfg_index = '0;
  logic [63:0]                  cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic signed [VALUE_BITS-1:0] in_value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [7:0]                   out_char_byte;
  logic                         out_last;

  char_rec_t pending_chars[$];
  stim_row_t stim_tab[$];

  logic [4:0]  sh_len = '0;
  logic [63:0] sh_low = '0;
  logic [63:0] sh_high = '0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int items_sent = 0;
  int silent_items = 0;
  int chars_seen = 0;
  int cfg_writes = 0;

  signed_int_to_radix_symbols_top #(
    .MAX_SYMBOLS(MAX_SYMBOLS),
    .VALUE_BITS (VALUE_BITS)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_byte(out_char_byte),
    .out_last     (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("FAIL signed_int_to_radix_symbols_top");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    if (err_cnt < 50) $display("MISMATCH at cycle %0d: %s", cycle_cnt, what);
    err_cnt++;
  endtask

  function automatic logic [7:0] sym_of(int k);
    return (k < 8) ? sh_low[8*k +: 8] : sh_high[8*(k-8) +: 8];
  endfunction

  function automatic bit alphabet_valid();
    logic [7:0] s;
    int i, j;
    if (sh_len < 2 || sh_len > SYM_COUNT) return 1'b0;
    for (i = 0; i < sh_len; i++) begin
      s = sym_of(i);
      if (s <= CHAR_SPACE || s >= CHAR_DEL || s == CHAR_MINUS || s == CHAR_PLUS)
        return 1'b0;
      for (j = i + 1; j < sh_len; j++)
        if (sym_of(j) == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void predict_radix_text(logic [31:0] v);
    int     base, nd, k;
    longint mag;
    int     digit[VALUE_BITS+1];
    if (!alphabet_valid()) begin
      silent_items++;
      return;
    end
    base = int'(sh_len);
    mag = longint'($signed(v));
    if (mag < 0) begin
      pending_chars.push_back('{CHAR_MINUS, 1'b0});
      mag = -mag;
    end
    nd = 0;
    do begin
      digit[nd] = int'(mag % base);
      mag = mag / base;
      nd++;
    end while (mag != 0);
    for (k = nd - 1; k >= 0; k--)
      pending_chars.push_back('{sym_of(digit[k]), k == 0});
  endfunction

  function automatic void push_text(string s);
    int i;
    for (i = 0; i < s.len(); i++)
      pending_chars.push_back('{s[i], i == s.len() - 1});
    if (s.len() == 0) silent_items++;
  endfunction

  function automatic logic [63:0] sym_word(string s, int first);
    logic [63:0] w;
    int k;
    w = '0;
    for (k = 0; k < 8; k++)
      if (first + k < s.len()) w[8*k +: 8] = s[first+k];
    return w;
  endfunction

  function automatic void add_cfg(logic [1:0] idx, logic [63:0] data);
    stim_tab.push_back('{ROW_CFG, idx, data, 32'd0, 1'b0, ""});
  endfunction

  function automatic void add_val(int v, bit typed, string txt);
    stim_tab.push_back('{ROW_VALUE, 2'd0, 64'd0, v, typed, txt});
  endfunction

  function automatic void add_alpha(string s, int len);
    add_cfg(CFG_SYMBOLS_LOW, sym_word(s, 0));
    add_cfg(CFG_SYMBOLS_HIGH, sym_word(s, 8));
    add_cfg(CFG_BASE_LENGTH, 64'(len));
  endfunction

  always @(posedge clk) begin : result_check
    char_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("character 0x%02h with none expected", out_char_byte));
      end else begin
        want = pending_chars.pop_front();
        chars_seen++;
        if (out_char_byte !== want.ch)
          report_mismatch($sformatf("char_byte 0x%02h, expected 0x%02h",
                                    out_char_byte, want.ch));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %b, expected %b", out_last, want.last));
      end
    end
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BASE_LENGTH:  sh_len  = data[4:0];
      CFG_SYMBOLS_LOW:  sh_low  = data;
      CFG_SYMBOLS_HIGH: sh_high = data;
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic send_value(logic [31:0] v, bit typed, string txt);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (typed) push_text(txt);
    else predict_radix_text(v);
  endtask

  task automatic settle_idle(int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic load_random_alphabet(int len, bit faulty);
    logic [7:0]   syms[16];
    logic [63:0]  low_w, high_w, len_w;
    alpha_fault_t fault;
    int           i, j, pos;
    bit           clash;
    for (i = 0; i < 16; i++) syms[i] = 8'($urandom);
    for (i = 0; i < len; i++) begin
      do begin
        syms[i] = 8'($urandom_range(126, 33));
        clash = (syms[i] == CHAR_PLUS) || (syms[i] == CHAR_MINUS);
        for (j = 0; j < i; j++)
          if (syms[j] == syms[i]) clash = 1'b1;
      end while (clash);
    end
    len_w = {$urandom, $urandom};
    len_w[4:0] = 5'(len);
    if (faulty) begin
      fault = alpha_fault_t'($urandom_range(FLT_DUP, FLT_SHORT));
      pos = $urandom_range(len - 1, 0);
      case (fault)
        FLT_SHORT: len_w[4:0] = 5'($urandom_range(1, 0));
        FLT_LONG:  len_w[4:0] = 5'($urandom_range(31, 17));
        FLT_CTRL:  syms[pos] = 8'($urandom_range(32, 0));
        FLT_TOP:   syms[pos] = 8'($urandom_range(255, 127));
        FLT_PLUS:  syms[pos] = CHAR_PLUS;
        FLT_MINUS: syms[pos] = CHAR_MINUS;
        default: begin
          i = $urandom_range(len - 2, 0);
          j = $urandom_range(len - 1, i + 1);
          syms[j] = syms[i];
        end
      endcase
    end
    for (i = 0; i < 8; i++) begin
      low_w[8*i +: 8]  = syms[i];
      high_w[8*i +: 8] = syms[i+8];
    end
    write_reg(CFG_SYMBOLS_LOW, low_w);
    write_reg(CFG_SYMBOLS_HIGH, high_w);
    write_reg(CFG_BASE_LENGTH, len_w);
  endtask

  function automatic logic [31:0] rand_value();
    longint p, v;
    int     pick, pb, k;
    pick = $urandom_range(99);
    if (pick < 40) return $urandom;
    if (pick < 60) return 32'($signed($urandom_range(600)) - 300);
    if (pick < 70) begin
      case ($urandom_range(6))
        0: return 32'h0000_0000;
        1: return 32'h0000_0001;
        2: return 32'hFFFF_FFFF;
        3: return 32'h7FFF_FFFF;
        4: return 32'h8000_0000;
        5: return 32'h7FFF_FFFE;
        default: return 32'h8000_0001;
      endcase
    end
    pb = (sh_len >= 2 && sh_len <= 16) ? int'(sh_len) : 10;
    p = 1;
    k = $urandom_range(31, 0);
    repeat (k) if (p * pb <= 64'h8000_0000) p = p * pb;
    v = p + $urandom_range(2) - 1;
    if ($urandom_range(1)) v = -v;
    return v[31:0];
  endfunction

  initial begin : stimulus
    int  r, ph, n, len;
    bit  after_value;
    add_val(0, 1'b1, "");
    add_val(32'h8000_0000, 1'b1, "");
    add_alpha("0123456789", 10);
    add_val(0, 1'b1, "0");
    add_val(32'h7FFF_FFFF, 1'b1, "2147483647");
    add_val(32'h8000_0000, 1'b1, "-2147483648");
    add_val(32'hFFFF_FFFF, 1'b1, "-1");
    add_cfg(CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    add_val(-1234567890, 1'b0, "");
    add_alpha("01", 2);
    add_val(32'h8000_0000, 1'b0, "");
    add_val(32'h7FFF_FFFF, 1'b0, "");
    add_alpha("0123456789ABCDEF", 16);
    add_val(32'h8000_0000, 1'b1, "-80000000");
    add_val(32'h7FFF_FFFF, 1'b1, "7FFFFFFF");
    add_val(32'hDEAD_BEEF, 1'b0, "");
    add_val(0, 1'b1, "0");
    add_alpha("!~?", 3);
    add_val(-7, 1'b0, "");
    add_val(0, 1'b1, "!");
    add_alpha("01234567", 8);
    add_cfg(CFG_SYMBOLS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    add_val(32'h1234_5678, 1'b0, "");
    add_cfg(CFG_BASE_LENGTH, 64'd17);
    add_val(5, 1'b1, "");
    add_cfg(CFG_BASE_LENGTH, 64'd31);
    add_val(-5, 1'b1, "");
    add_cfg(CFG_BASE_LENGTH, 64'd1);
    add_val(0, 1'b1, "");
    add_alpha("0 ", 2);
    add_val(1, 1'b1, "");
    add_cfg(CFG_SYMBOLS_LOW, {48'd0, CHAR_DEL, 8'h30});
    add_val(1, 1'b1, "");
    add_cfg(CFG_SYMBOLS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    add_val(2, 1'b1, "");
    add_alpha("ab+", 3);
    add_val(3, 1'b1, "");
    add_alpha("a-b", 3);
    add_val(4, 1'b1, "");
    add_alpha("abcb", 4);
    add_val(9, 1'b1, "");

    tx_idle_pct = 35;
    rx_idle_pct = 80;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    after_value = 1'b0;
    for (r = 0; r < stim_tab.size(); r++) begin
      if (stim_tab[r].kind == ROW_CFG) begin
        if (after_value) settle_idle(SETTLE_CYCLES);
        write_reg(stim_tab[r].index, stim_tab[r].data);
        after_value = 1'b0;
      end else begin
        send_value(stim_tab[r].value, stim_tab[r].typed, stim_tab[r].text);
        after_value = 1'b1;
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == 4) begin
        tx_idle_pct = 80;
        rx_idle_pct = 35;
      end else if (ph == 7) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      settle_idle(SETTLE_CYCLES);
      len = (ph == 0) ? 2 : (ph == 1) ? 16 : $urandom_range(16, 2);
      load_random_alphabet(len, ph == 3 || ph == 8);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 5 && n == PHASE_ITEMS / 2) settle_idle(0);
        send_value(rand_value(), 1'b0, "");
      end
    end

    settle_idle(SETTLE_CYCLES);
    $display("Run covered %0d values (%0d under a rejected alphabet), %0d register writes",
             items_sent, silent_items, cfg_writes);
    $display("and %0d checked characters in radices 2 to 16; %0d mismatches.",
             chars_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("PASS signed_int_to_radix_symbols_top");
    end else begin
      $display("FAIL signed_int_to_radix_symbols_top");
    end
    $finish;
  end

endmodule
